/* sv/tph_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and CORDIC step for the tilt peak height block.
package tph_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [4:0] CORDIC_LAST = 5'd29;
  localparam logic [4:0] SQRT_LAST = 5'd31;

  localparam logic [12:0] ANGLE_LIMIT = 13'd5760;
  localparam logic [28:0] DEG64_TO_RAD_Q40 = 29'd299845282;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [8:0] TILT_MAX = 9'd314;
  localparam logic [7:0] HEIGHT_MAX = 8'd250;
  // code * 2^30 / 200 = code * floor(2^27/25) + floor(3 * code / 25)
  localparam logic [22:0] CODE_TO_Q30_INT = 23'd5368709;
  localparam logic [11:0] CODE_TO_Q30_FRAC = 12'd3933;

  typedef logic signed [33:0] cval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } cstate_t;

  typedef struct packed {
    logic [30:0] roll;
    logic [30:0] pitch;
  } angle_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd843314856;
      5'd1: r = 30'd497837829;
      5'd2: r = 30'd263043836;
      5'd3: r = 30'd133525158;
      5'd4: r = 30'd67021686;
      5'd5: r = 30'd33543515;
      5'd6: r = 30'd16775850;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194282;
      5'd9: r = 30'd2097149;
      default: r = 30'((31'd1 << (5'd30 - i)) - 31'd1);
    endcase
    return r;
  endfunction

  // One micro-rotation; vec selects vectoring (drive y to zero) over rotation.
  function automatic cstate_t cordic_step(input cstate_t s, input logic [4:0] i,
                                          input logic vec);
    cstate_t r;
    cval_t tx;
    cval_t ty;
    cval_t dx;
    cval_t dy;
    cval_t a;
    logic cw;
    tx = s.x;
    ty = s.y;
    dx = ty >>> i;
    dy = tx >>> i;
    a = $signed({4'b0, atan_q30(i)});
    if (vec) begin
      cw = !ty[33] && (ty != '0);
    end else begin
      cw = s.z[33];
    end
    if (cw) begin
      r.x = tx + dx;
      r.y = ty - dy;
      r.z = s.z + a;
    end else begin
      r.x = tx - dx;
      r.y = ty + dy;
      r.z = s.z - a;
    end
    return r;
  endfunction

endpackage

/* sv/tph_front.sv */
`timescale 1ns / 1ps
// Front end: takes requests, folds angles to magnitudes and converts to Q30 radians.
module tph_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [13:0]       roll_angle,
  input  logic signed [13:0]       pitch_angle,
  input  tph_pkg::q_status_t       q_status,
  output logic                     push,
  output tph_pkg::angle_pair_t     push_data
);

  logic        stage_valid;
  logic [13:0] stage_roll;
  logic [13:0] stage_pitch;

  function automatic logic [30:0] to_q30(input logic [13:0] raw);
    logic [13:0] mag;
    logic [12:0] sat;
    logic [41:0] prod;
    mag = raw[13] ? 14'(15'h4000 - {1'b0, raw}) : raw;
    sat = (mag > {1'b0, tph_pkg::ANGLE_LIMIT}) ? tph_pkg::ANGLE_LIMIT : mag[12:0];
    prod = {29'd0, sat} * {13'd0, tph_pkg::DEG64_TO_RAD_Q40};
    return prod[40:10];
  endfunction

  assign push = stage_valid && !q_status.full;
  assign in_ready = !stage_valid || !q_status.full;
  assign push_data.roll = to_q30(stage_roll);
  assign push_data.pitch = to_q30(stage_pitch);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_roll <= roll_angle;
      stage_pitch <= pitch_angle;
    end
  end

endmodule

/* sv/tph_queue.sv */
`timescale 1ns / 1ps
// Short queue of converted angle pairs between front and back.
module tph_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  tph_pkg::angle_pair_t     push_data,
  input  logic                     pop,
  output tph_pkg::angle_pair_t     pop_data,
  output tph_pkg::q_status_t       status
);

  localparam int PW = $clog2(tph_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(tph_pkg::QUEUE_DEPTH + 1);

  tph_pkg::angle_pair_t mem [tph_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full = (count == CW'(tph_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/tph_back.sv */
`timescale 1ns / 1ps
// Back end: CORDIC, square root and peak sequencer with history and output register.
module tph_back #(
  parameter int HISTORY_SPAN = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tph_pkg::q_status_t       q_status,
  output logic                     pop,
  input  tph_pkg::angle_pair_t     pop_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [8:0]               tilt_code,
  output logic                     peak_found,
  output logic [7:0]               peak_height
);

  localparam int HIST_DEPTH = 2 * HISTORY_SPAN;
  localparam int FW = $clog2(HIST_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROT  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_SQR  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_VEC  = 4'd6;
  localparam logic [3:0] S_CODE = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state;
  logic [4:0] cnt;
  tph_pkg::cstate_t la;
  tph_pkg::cstate_t lb;
  logic [30:0] hang;
  logic [31:0] u, v, den;
  logic [63:0] squ, sqv;
  logic [63:0] rem, root;
  logic [8:0] code_r;
  logic [7:0] height_r;
  logic [8:0] hist [HIST_DEPTH];
  logic [FW-1:0] fill;

  logic [8:0] mid;
  logic [8:0] old;
  logic [31:0] hang_int;
  logic [20:0] hang_frac;
  logic [63:0] pu, pv, pd;
  logic [63:0] sbit, strial;
  logic [63:0] root_next;
  logic [39:0] pcode, pheight;
  tph_pkg::cval_t hdiff;
  logic found;
  logic out_free;

  function automatic logic [31:0] mag32(input tph_pkg::cval_t a);
    tph_pkg::cval_t n;
    n = a[33] ? -a : a;
    return n[31:0];
  endfunction

  assign mid = hist[HISTORY_SPAN-1];
  assign old = hist[HIST_DEPTH-1];
  assign hang_int = {23'd0, mid} * {9'd0, tph_pkg::CODE_TO_Q30_INT};
  assign hang_frac = {12'd0, mid} * {9'd0, tph_pkg::CODE_TO_Q30_FRAC};

  // la holds roll cos/sin, lb holds pitch cos/sin after rotation
  assign pu = {32'd0, mag32(la.y)} * {32'd0, mag32(lb.x)};
  assign pv = {32'd0, mag32(lb.y)} * {32'd0, mag32(la.x)};
  assign pd = {32'd0, mag32(la.x)} * {32'd0, mag32(lb.x)};

  assign sbit = 64'd1 << (7'd62 - {1'b0, cnt, 1'b0});
  assign strial = root + sbit;
  assign root_next = (rem >= strial) ? (root >> 1) + sbit : root >> 1;

  assign pcode = {8'd0, la.z[31:0]} * 40'd200;
  assign hdiff = tph_pkg::ONE_Q30 - lb.x;
  assign pheight = {8'd0, hdiff[31:0]} * 40'd250;

  assign found = (fill == FW'(HIST_DEPTH)) && (old <= mid) && (code_r < mid);
  assign out_free = !out_valid || out_ready;
  assign pop = (state == S_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
      fill <= '0;
      for (int j = 0; j < HIST_DEPTH; j++) begin
        hist[j] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            la <= '{x: tph_pkg::GAIN_Q30, y: '0, z: $signed({3'b0, pop_data.roll})};
            lb <= '{x: tph_pkg::GAIN_Q30, y: '0, z: $signed({3'b0, pop_data.pitch})};
            hang <= hang_int[30:0] + {25'd0, hang_frac[20:15]};
            cnt <= '0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          la <= tph_pkg::cordic_step(la, cnt, 1'b0);
          lb <= tph_pkg::cordic_step(lb, cnt, 1'b0);
          cnt <= cnt + 1'b1;
          if (cnt == tph_pkg::CORDIC_LAST) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          u <= pu[61:30];
          v <= pv[61:30];
          den <= pd[61:30];
          state <= S_SQR;
        end
        S_SQR: begin
          squ <= {32'd0, u} * {32'd0, u};
          sqv <= {32'd0, v} * {32'd0, v};
          state <= S_SUM;
        end
        S_SUM: begin
          rem <= squ + sqv;
          root <= '0;
          cnt <= '0;
          // height rotation for the candidate peak runs beside the root
          lb <= '{x: tph_pkg::GAIN_Q30, y: '0, z: $signed({3'b0, hang})};
          state <= S_SQRT;
        end
        S_SQRT: begin
          root <= root_next;
          if (rem >= strial) begin
            rem <= rem - strial;
          end
          if (cnt <= tph_pkg::CORDIC_LAST) begin
            lb <= tph_pkg::cordic_step(lb, cnt, 1'b0);
          end
          if (cnt == tph_pkg::SQRT_LAST) begin
            // load the vectoring pass from the finished root
            la <= '{x: $signed({2'b0, den}), y: $signed({2'b0, root_next[31:0]}), z: '0};
            cnt <= '0;
            state <= S_VEC;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_VEC: begin
          la <= tph_pkg::cordic_step(la, cnt, 1'b1);
          cnt <= cnt + 1'b1;
          if (cnt == tph_pkg::CORDIC_LAST) begin
            state <= S_CODE;
          end
        end
        S_CODE: begin
          if (la.z[33]) begin
            code_r <= '0;
          end else if (pcode[39:30] > {1'b0, tph_pkg::TILT_MAX}) begin
            code_r <= tph_pkg::TILT_MAX;
          end else begin
            code_r <= pcode[38:30];
          end
          if (lb.x >= tph_pkg::ONE_Q30) begin
            height_r <= '0;
          end else if (pheight[39:30] > {2'b0, tph_pkg::HEIGHT_MAX}) begin
            height_r <= tph_pkg::HEIGHT_MAX;
          end else begin
            height_r <= pheight[37:30];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tilt_code <= code_r;
            peak_found <= found;
            peak_height <= found ? height_r : '0;
            for (int j = HIST_DEPTH - 1; j > 0; j--) begin
              hist[j] <= hist[j-1];
            end
            hist[0] <= code_r;
            if (fill != FW'(HIST_DEPTH)) begin
              fill <= fill + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/tilt_peak_height.sv */
`timescale 1ns / 1ps
// Tilt angle of a roll/pitch sample with swing peak detection and peak height.
//
// Each request carries roll and pitch in 1/64 degree and gives one result: the
// total tilt in radians times 200, and on a swing peak the height
// 250*(1-cos(peak/200)). The front end converts angles and queues them two deep;
// the back end works one item at a time on a shared iterative engine, whose steps
// are a 30-step CORDIC rotation of both angles, three products,
// a 32-step square root (alongside a 30-step rotation for the candidate peak's
// cosine), a 30-step vectoring CORDIC, and scaling. A finished result sits in
// the output register while the next item is already under way.
module tilt_peak_height #(
  parameter int HISTORY_SPAN = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [13:0] roll_angle,
  input  logic signed [13:0] pitch_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         tilt_code,
  output logic               peak_found,
  output logic [7:0]         peak_height
);

  tph_pkg::q_status_t   q_status;
  tph_pkg::angle_pair_t push_data;
  tph_pkg::angle_pair_t pop_data;
  logic                 push;
  logic                 pop;

  tph_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  tph_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  tph_back #(
    .HISTORY_SPAN (HISTORY_SPAN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .pop         (pop),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tilt_code   (tilt_code),
    .peak_found  (peak_found),
    .peak_height (peak_height)
  );

  a_no_height_without_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && !peak_found |-> peak_height == 8'd0)
    else $error("peak height without a peak");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tilt_code <= tph_pkg::TILT_MAX && peak_height <= tph_pkg::HEIGHT_MAX)
    else $error("result out of range");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue overrun");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for tilt_peak_height: tilt code, swing peak and peak height checks.
module tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [13:0] roll_angle;
  logic signed [13:0] pitch_angle;
  logic               out_valid;
  logic               out_ready;
  logic [8:0]         tilt_code;
  logic               peak_found;
  logic [7:0]         peak_height;

  typedef struct packed {
    logic [8:0] code;
    logic       found;
    logic [7:0] height;
  } tilt_result_t;

  localparam int SPAN = 2;
  localparam int DEPTH = 2 * SPAN;

  tilt_result_t pending_results[$];
  int           error_count = 0;
  bit           steady = 0;
  logic [8:0]   code_hist[DEPTH];
  int           hist_fill;

  tilt_peak_height #(.HISTORY_SPAN(SPAN)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .tilt_code(tilt_code), .peak_found(peak_found), .peak_height(peak_height)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint arctan_q30(input int i);
    longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return head[i];
    return (longint'(1) << (30 - i)) - 1;
  endfunction

  function automatic void rotate_q30(input longint theta, output longint c,
                                     output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = theta;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_angle(input longint num, input longint den);
    longint x, y, z, dx, dy;
    x = den;
    y = num;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_q30(i);
      end else begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint to_radians_q30(input logic [13:0] raw);
    longint unsigned m;
    m = raw[13] ? (64'd16384 - raw) : raw;
    if (m > 5760) m = 5760;
    return longint'((m * 64'd299845282) >> 10);
  endfunction

  function automatic longint unsigned mag_mul_q30(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p < 0) p = -p;
    return longint'(p) >>> 30;
  endfunction

  function automatic logic [8:0] tilt_of(input logic [13:0] r, input logic [13:0] p);
    longint cr, sr, cp, sp, z;
    longint unsigned u, v, den, num, code;
    rotate_q30(to_radians_q30(r), cr, sr);
    rotate_q30(to_radians_q30(p), cp, sp);
    u = mag_mul_q30(sr, cp);
    v = mag_mul_q30(sp, cr);
    den = mag_mul_q30(cr, cp);
    num = floor_sqrt(u * u + v * v);
    z = vector_angle(longint'(num), longint'(den));
    if (z < 0) return 9'd0;
    code = (longint'(z) * 200) >> 30;
    return code > 314 ? 9'd314 : code[8:0];
  endfunction

  function automatic logic [7:0] swing_height(input logic [8:0] code);
    longint c, s;
    longint unsigned h;
    rotate_q30(longint'((64'(code) << 30) / 200), c, s);
    if (c >= 64'sd1073741824) return 8'd0;
    h = ((64'd1073741824 - c) * 250) >> 30;
    return h > 250 ? 8'd250 : h[7:0];
  endfunction

  function automatic tilt_result_t predict_tilt(input logic [13:0] r,
                                                input logic [13:0] p);
    tilt_result_t res;
    res.code = tilt_of(r, p);
    res.found = 1'b0;
    res.height = 8'd0;
    if (hist_fill >= DEPTH) begin
      if (code_hist[DEPTH-1] <= code_hist[SPAN-1] && res.code < code_hist[SPAN-1]) begin
        res.found = 1'b1;
        res.height = swing_height(code_hist[SPAN-1]);
      end
    end
    for (int j = DEPTH - 1; j > 0; j--) code_hist[j] = code_hist[j-1];
    code_hist[0] = res.code;
    if (hist_fill < DEPTH) hist_fill++;
    return res;
  endfunction

  task automatic send_request(input logic [13:0] r, input logic [13:0] p);
    if (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_valid <= 1'b1;
    roll_angle <= r;
    pitch_angle <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), predict_tilt(r, p));
  endtask

  // hold a swing: triangle in both axes, random amplitude and sign
  task automatic send_swing(input int steps, input int amp_r, input int amp_p);
    int k, r, p, sr, sp;
    sr = $urandom_range(1) ? 1 : -1;
    sp = $urandom_range(1) ? 1 : -1;
    for (k = -steps; k <= steps; k++) begin
      r = sr * amp_r * (steps - (k < 0 ? -k : k)) / steps;
      p = sp * amp_p * (steps - (k < 0 ? -k : k)) / steps;
      if ($urandom_range(3) == 0) r += int'($urandom_range(40)) - 20;
      send_request(14'(r), 14'(p));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: tilt_code %0d", tilt_code);
          error_count++;
        end else begin
          tilt_result_t want;
          want = pending_results.pop_front();
          if (tilt_code !== want.code) begin
            $error("tilt_code expected %0d actual %0d", want.code, tilt_code);
            error_count++;
          end
          if (peak_found !== want.found) begin
            $error("peak_found expected %0d actual %0d", want.found, peak_found);
            error_count++;
          end
          if (peak_height !== want.height) begin
            $error("peak_height expected %0d actual %0d", want.height, peak_height);
            error_count++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 32);
    end
  end

  task automatic test_extremes();
    send_request(14'sd0, 14'sd0);
    send_request(14'sd5760, 14'sd5760);
    send_request(-14'sd5760, -14'sd5760);
    send_request(14'sd5760, 14'sd0);
    send_request(14'sd0, -14'sd5760);
    send_request(14'sd8191, -14'sd8192);
    send_request(-14'sd8192, 14'sd8191);
    send_request(14'sd5761, -14'sd5761);
    send_request(14'sd1, -14'sd1);
    send_request(-14'sd1, 14'sd0);
  endtask

  task automatic test_peaks();
    // rise, fall, then a flat top and a lower old code
    send_request(14'sd0, 14'sd0);
    send_request(14'sd1000, 14'sd0);
    send_request(14'sd3000, 14'sd500);
    send_request(14'sd1000, 14'sd0);
    send_request(14'sd0, 14'sd0);
    send_request(14'sd3000, 14'sd3000);
    send_request(14'sd3000, 14'sd3000);
    send_request(14'sd3000, 14'sd3000);
    send_request(14'sd200, 14'sd0);
    send_request(14'sd5760, 14'sd5760);
    send_request(-14'sd5760, 14'sd5760);
    send_request(14'sd0, 14'sd0);
    send_request(14'sd0, 14'sd0);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 2000) begin
      steady = (sent >= 600 && sent < 900);
      if ($urandom_range(9) < 7) begin
        int n;
        n = $urandom_range(12, 2);
        send_swing(n, $urandom_range(5760), $urandom_range(5760));
        sent += 2 * n + 1;
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_request(14'($urandom), 14'($urandom));
          sent++;
        end
      end
    end
    steady = 0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    roll_angle = '0;
    pitch_angle = '0;
    hist_fill = 0;
    for (int j = 0; j < DEPTH; j++) code_hist[j] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_peaks();
    test_random();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("tilt_peak_height test passed");
    end else begin
      $display("tilt_peak_height test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tilt_peak_height test failed");
    $finish;
  end

endmodule
